/* hw/rtl/five_way_key_debouncer_unit_macros.svh */
// ----------------------------------------------------------------------------
// Key debouncer assertion macros
// Shared concurrent assertion shorthands on i_clk, with and without reset.
// ----------------------------------------------------------------------------
`ifndef FIVE_WAY_KEY_DEBOUNCER_UNIT_MACROS_SVH
`define FIVE_WAY_KEY_DEBOUNCER_UNIT_MACROS_SVH

// Checked only while out of reset.
`define FWKD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define FWKD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hw/rtl/fwkd_pkg.sv */
// ----------------------------------------------------------------------------
// fwkd_pkg
// Constants, types and the key priority function of the key debouncer.
// ----------------------------------------------------------------------------
`default_nettype none

package fwkd_pkg;

    localparam int NUM_KEYS     = 5;
    localparam int BUTTON_COUNT = 5;
    // lanes actually built: only real buttons below NUM_KEYS are debounced
    localparam int NUM_LANES    = (NUM_KEYS < BUTTON_COUNT) ? NUM_KEYS : BUTTON_COUNT;

    localparam int CNT_W  = 8;
    localparam int CODE_W = 3;

    localparam logic [CNT_W-1:0] THRESHOLD_RESET = 8'd4;

    // button bit positions
    localparam int BIT_LEFT   = 0;
    localparam int BIT_RIGHT  = 1;
    localparam int BIT_UP     = 2;
    localparam int BIT_DOWN   = 3;
    localparam int BIT_CENTER = 4;

    // key codes
    localparam logic [CODE_W-1:0] KEY_NONE   = 3'd0;
    localparam logic [CODE_W-1:0] KEY_CENTER = 3'd1;
    localparam logic [CODE_W-1:0] KEY_LEFT   = 3'd2;
    localparam logic [CODE_W-1:0] KEY_RIGHT  = 3'd3;
    localparam logic [CODE_W-1:0] KEY_UP     = 3'd4;
    localparam logic [CODE_W-1:0] KEY_DOWN   = 3'd5;

    // word opcodes (carried in tuser)
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef logic [BUTTON_COUNT-1:0] t_mask;

    typedef struct packed {
        t_mask             pending_mask;
        logic [CODE_W-1:0] key_code;
    } t_result;

    // priority: center, left, right, up, down
    function automatic logic [CODE_W-1:0] key_of(input t_mask pend);
        logic [CODE_W-1:0] code;
        code = KEY_NONE;
        if (pend[BIT_CENTER])     code = KEY_CENTER;
        else if (pend[BIT_LEFT])  code = KEY_LEFT;
        else if (pend[BIT_RIGHT]) code = KEY_RIGHT;
        else if (pend[BIT_UP])    code = KEY_UP;
        else if (pend[BIT_DOWN])  code = KEY_DOWN;
        return code;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/fwkd_lane.sv */
// ----------------------------------------------------------------------------
// fwkd_lane
// Integrating counter for one button; flags a latched press on a tick.
// ----------------------------------------------------------------------------
`default_nettype none

module fwkd_lane
    import fwkd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_tick,      // accepted sampling tick
    input  wire logic             i_level,     // button pressed
    input  wire logic [CNT_W-1:0] i_threshold,
    output logic                  o_set        // press latches on this tick
);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             at_thr;

    assign at_thr = (r_cnt >= i_threshold);
    assign o_set  = i_tick && i_level && at_thr;

    always_comb begin
        n_cnt = r_cnt;
        if (i_tick) begin
            if (i_level) begin
                n_cnt = at_thr ? '0 : r_cnt + 1'b1;
            end else if (r_cnt != '0) begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/fwkd_merge.sv */
// ----------------------------------------------------------------------------
// fwkd_merge
// Merges lane press flags into the pending latch; priority read and clear.
// ----------------------------------------------------------------------------
`default_nettype none

`include "five_way_key_debouncer_unit_macros.svh"

module fwkd_merge
    import fwkd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_accept,  // word accepted this cycle
    input  wire logic  i_read,    // accepted word is a read
    input  wire t_mask i_set,     // lane press flags
    output t_result    o_result   // result of the current word
);

    t_mask r_pending;
    t_mask n_pending;

    always_comb begin
        n_pending = (i_read == OP_READ) ? '0 : (r_pending | i_set);
        o_result.pending_mask = n_pending;
        o_result.key_code     = (i_read == OP_READ) ? key_of(r_pending) : KEY_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (i_accept) begin
            r_pending <= n_pending;
        end
    end

    `FWKD_ASSERT(a_read_clears, (i_accept && i_read) |=> (r_pending == '0), "read left pending bits")
    `FWKD_ASSERT(a_tick_no_key, (!i_read) |-> (o_result.key_code == KEY_NONE), "key on tick")
    `FWKD_ASSERT(a_tick_keeps, (i_accept && !i_read) |=> ((r_pending & $past(r_pending)) == $past(r_pending)), "tick dropped a pending bit")
    `FWKD_ASSERT(a_key_pending, (o_result.key_code != KEY_NONE) |-> (r_pending != '0), "key without pending bit")

endmodule

`default_nettype wire

/* hw/rtl/five_way_key_debouncer_unit.sv */
// ----------------------------------------------------------------------------
// five_way_key_debouncer_unit
// Five-button navigation key debouncer with integrating counters.
// ----------------------------------------------------------------------------
// Takes one word per clock while the output register can take it and returns
// one result word per input word, in order, through the output register. A tick word
// (tuser = 0) samples the button levels: each pressed button's 8-bit counter
// counts up until it equals press_threshold, the next pressed tick latches
// the button's pending bit and zeroes the counter; released buttons count
// down to zero. A read word (tuser = 1) returns the highest-priority pending
// key (center, left, right, up, down) and clears all pending bits. Every
// result also carries the pending mask after the word. The five counters run
// as parallel lanes and a merge stage updates the pending latch, so the rate
// is one word per cycle, limited only by the output register draining.
// press_threshold sits at APB byte address 0 and must be written only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module five_way_key_debouncer_unit
    import fwkd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [4:0] buttons_level, [7:5] zero
    input  wire logic        s_axis_tuser,   // [0] opcode
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [2:0] key_code, [7:3] pending_mask
    // APB config
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [CNT_W-1:0] r_threshold;
    logic             accept;
    logic             tick;
    t_mask            set_mask;
    t_result          result;
    logic             r_out_valid;
    t_result          r_out;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {{(32-CNT_W){1'b0}}, r_threshold} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_threshold <= pwdata[CNT_W-1:0];
        end
    end

    // ---------------- handshake ----------------
    // output register frees up in the same cycle it drains
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign tick          = accept && (s_axis_tuser == OP_TICK);

    // ---------------- counter lanes ----------------
    genvar g;
    generate
        for (g = 0; g < BUTTON_COUNT; g++) begin : g_lane
            if (g < NUM_LANES) begin : g_on
                fwkd_lane u_lane (
                    .i_clk       (i_clk),
                    .i_rst_n     (i_rst_n),
                    .i_tick      (tick),
                    .i_level     (s_axis_tdata[g]),
                    .i_threshold (r_threshold),
                    .o_set       (set_mask[g])
                );
            end else begin : g_off
                // button not debounced: never latches
                assign set_mask[g] = 1'b0;
            end
        end
    endgenerate

    // ---------------- merge / pending latch ----------------
    fwkd_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_read   (s_axis_tuser),
        .i_set    (set_mask),
        .o_result (result)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule

`default_nettype wire

/* bench/five_way_key_debouncer_checker.sv */
// ----------------------------------------------------------------------------
// Key debouncer scoreboard
// Snoops the input stream, the result stream and APB writes, keeps its own
// copy of the integrating counters and the pending latch, and compares every
// result word field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module five_way_key_debouncer_checker
    import fwkd_pkg::*;
#(
    parameter logic [2:0] THRESH_ADDR = 3'd0
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [4:0] buttons_level, [7:5] zero
    input  wire logic        i_s_tuser,   // [0] opcode
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [7:0]  i_m_tdata,   // [2:0] key_code, [7:3] pending_mask
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    input  wire logic        i_pready,
    output int unsigned      o_error_count,
    output int unsigned      o_words_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    // scan order of the read: center first, down last
    localparam int                PRIO_BIT  [BUTTON_COUNT] =
        '{BIT_CENTER, BIT_LEFT, BIT_RIGHT, BIT_UP, BIT_DOWN};
    localparam logic [CODE_W-1:0] PRIO_CODE [BUTTON_COUNT] =
        '{KEY_CENTER, KEY_LEFT, KEY_RIGHT, KEY_UP, KEY_DOWN};

    logic [CNT_W-1:0] press_count [NUM_KEYS];
    t_mask            latched;
    logic [CNT_W-1:0] threshold;
    t_result          result_q [$];
    int unsigned      errs;

    function automatic t_result debounce_word(input logic op, input t_mask levels);
        t_result res;
        logic    found;
        res   = '0;
        found = 1'b0;
        if (op == OP_TICK) begin
            for (int i = 0; i < NUM_KEYS && i < BUTTON_COUNT; i++) begin
                if (levels[i]) begin
                    if (press_count[i] < threshold) begin
                        press_count[i] = press_count[i] + 1'b1;
                    end else begin
                        latched[i]     = 1'b1;
                        press_count[i] = '0;
                    end
                end else if (press_count[i] != '0) begin
                    press_count[i] = press_count[i] - 1'b1;
                end
            end
        end else begin
            for (int k = 0; k < BUTTON_COUNT; k++) begin
                if (!found && latched[PRIO_BIT[k]]) begin
                    res.key_code = PRIO_CODE[k];
                    found        = 1'b1;
                end
            end
            latched = '0;
        end
        res.pending_mask = latched;
        return res;
    endfunction

    always @(posedge i_clk) begin : snoop
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            foreach (press_count[i]) press_count[i] = '0;
            latched   = '0;
            threshold = THRESHOLD_RESET;
            result_q.delete();
            errs      = 0;
        end else begin
            // a result leaving now was accepted on an earlier edge
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata);
                if (result_q.size() == 0) begin
                    $error("unexpected result word: key_code %0d pending_mask %0h",
                           got.key_code, got.pending_mask);
                    errs++;
                end else begin
                    want = result_q.pop_front();
                    if (got.key_code !== want.key_code) begin
                        $error("key_code mismatch: expected %0d, actual %0d",
                               want.key_code, got.key_code);
                        errs++;
                    end
                    if (got.pending_mask !== want.pending_mask) begin
                        $error("pending_mask mismatch: expected %0h, actual %0h",
                               want.pending_mask, got.pending_mask);
                        errs++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                result_q.push_back(debounce_word(i_s_tuser, t_mask'(i_s_tdata[4:0])));
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == THRESH_ADDR)
                threshold = i_pwdata[CNT_W-1:0];
        end
        o_error_count     <= errs;
        o_words_in_flight <= result_q.size();
    end

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// Key debouncer testbench
// Drives tick and read words with random gaps against a randomly stalling
// sink, reprograms the press threshold between phases, and leaves checking
// to the scoreboard beside the DUT.
// ----------------------------------------------------------------------------
module tb
    import fwkd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_PRESS_THRESHOLD = 3'd0;
    localparam int         STALL_LIMIT          = 2000;  // cycles with no transfer at all
    localparam int         DRAIN_TAIL           = 3;     // margin after the last predicted result returns

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [4:0] buttons_level, [7:5] zero
    logic        s_axis_tuser  = 1'b0; // [0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [2:0] key_code, [7:3] pending_mask
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    int unsigned error_count;
    int unsigned words_in_flight;

    // sender pacing state
    int unsigned burst_left = 0;

    five_way_key_debouncer_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    five_way_key_debouncer_checker #(
        .THRESH_ADDR (ADDR_PRESS_THRESHOLD)
    ) i_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s_tvalid        (s_axis_tvalid),
        .i_s_tready        (s_axis_tready),
        .i_s_tdata         (s_axis_tdata),
        .i_s_tuser         (s_axis_tuser),
        .i_m_tvalid        (m_axis_tvalid),
        .i_m_tready        (m_axis_tready),
        .i_m_tdata         (m_axis_tdata),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .i_pready          (pready),
        .o_error_count     (error_count),
        .o_words_in_flight (words_in_flight)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sink: mostly short ready runs and short stalls, now and then a long
    // stall, and occasional long runs with tready held high.
    always @(negedge i_clk) begin : sink_pacing
        int unsigned stall_left;
        int unsigned free_left;
        int unsigned roll;
        if (stall_left == 0 && free_left == 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 60)      free_left  = $urandom_range(1, 8);
            else if (roll < 90) stall_left = $urandom_range(1, 3);
            else if (roll < 97) stall_left = $urandom_range(4, 20);
            else                free_left  = $urandom_range(50, 200);
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            free_left--;
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: a hung handshake on either side ends the run.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (psel && penable && pready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // One word on the input stream. Returns at the falling edge after the
    // transfer with tvalid still high, so back-to-back words need no dip.
    task automatic send_word(input logic op, input logic [4:0] levels);
        int unsigned gap;
        int unsigned roll;
        gap = 0;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 3)       burst_left = $urandom_range(30, 100);
            else if (roll < 65) gap = 0;
            else if (roll < 93) gap = $urandom_range(1, 3);
            else                gap = $urandom_range(8, 40);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, levels};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Stop sending and let every predicted result come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (words_in_flight != 0) @(negedge i_clk);
        repeat (DRAIN_TAIL) @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_PRESS_THRESHOLD;
        pwdata  <= {24'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random phase: mostly held button patterns for runs around the
    // threshold so presses actually latch, sprinkled with single-bit
    // bounce, reads after some runs, and a share of pure noise words.
    task automatic run_phase(input int thr, input int count);
        int          sent;
        int          run;
        logic [4:0]  held;
        logic [4:0]  lv;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 15) begin
                send_word($urandom_range(0, 1) ? OP_READ : OP_TICK, 5'($urandom_range(0, 31)));
                sent++;
            end else begin
                held = 5'($urandom_range(0, 31));
                run  = $urandom_range(1, thr + thr / 4 + 3);
                for (int k = 0; k < run && sent < count; k++) begin
                    lv = held;
                    if ($urandom_range(0, 15) == 0) lv[$urandom_range(0, 4)] ^= 1'b1;
                    send_word(OP_TICK, lv);
                    sent++;
                end
                if (sent < count && $urandom_range(0, 2) == 0) begin
                    send_word(OP_READ, 5'($urandom_range(0, 31)));
                    sent++;
                    // now and then the sender holds off until the pipe is empty
                    if ($urandom_range(0, 19) == 0) drain();
                end
            end
        end
    endtask

    initial begin : stimulus
        int          phase_thr [7];
        int          phase_len [7];
        phase_thr = '{1, 255, 2, 0, 0, 0, 0};
        phase_len = '{250, 600, 250, 250, 250, 250, 150};
        for (int p = 3; p < 6; p++) phase_thr[p] = $urandom_range(3, 12);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed, reset threshold of 4 ---
        send_word(OP_READ, 5'h1F);                  // nothing pending, levels ignored
        repeat (5) send_word(OP_TICK, 5'h1F);       // fifth tick latches every button
        send_word(OP_READ, 5'h00);                  // center wins, latch cleared
        repeat (3) send_word(OP_TICK, 5'h01);
        send_word(OP_TICK, 5'h00);                  // released: counter steps back
        repeat (2) send_word(OP_TICK, 5'h01);       // at threshold, not latched yet
        send_word(OP_READ, 5'h1F);                  // counters untouched by a read
        drain();

        // --- directed, threshold zero: every pressed tick latches ---
        write_threshold(8'd0);
        send_word(OP_TICK, 5'h0F);
        send_word(OP_READ, 5'h00);                  // left
        send_word(OP_TICK, 5'h0E);
        send_word(OP_READ, 5'h00);                  // right
        send_word(OP_TICK, 5'h0C);
        send_word(OP_READ, 5'h00);                  // up
        send_word(OP_TICK, 5'h08);
        send_word(OP_READ, 5'h00);                  // down
        send_word(OP_TICK, 5'h10);
        send_word(OP_READ, 5'h00);                  // center
        send_word(OP_READ, 5'h00);                  // none
        run_phase(0, 100);

        // --- random phases, threshold changed only while idle ---
        foreach (phase_thr[p]) begin
            drain();
            write_threshold(8'(phase_thr[p]));
            run_phase(phase_thr[p], phase_len[p]);
        end
        drain();

        if (error_count == 0 && words_in_flight == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
